### sv/tbd_pkg.sv
// ----------------------------------------------------------------------------
// tbd_pkg: shared types and constants of the tar block stream deframer
// Phase and scan-state encodings, byte kind codes, header field offsets and
// field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tbd_pkg;

    // Archive block size in bytes
    localparam int BLOCK_BYTES_DEF = 512;

    // Parsed field widths
    localparam int SMALL_W = 24;
    localparam int LARGE_W = 36;

    // Octal header field offsets within a header block
    localparam int OFS_MODE       = 100;
    localparam int OFS_UID        = 108;
    localparam int OFS_GID        = 116;
    localparam int OFS_SIZE       = 124;
    localparam int OFS_MTIME      = 136;
    localparam int OFS_FIELDS_END = 148;

    // Byte kind codes
    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_DATA   = 3'd1;
    localparam logic [2:0] KIND_PAD    = 3'd2;
    localparam logic [2:0] KIND_ZERO   = 3'd3;
    localparam logic [2:0] KIND_AFTER  = 3'd4;

    // Stream phase
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_PAD,
        PH_DONE
    } t_phase;

    // Octal field scan state
    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_DIGITS,
        SCAN_STOPPED
    } t_scan;

endpackage

`default_nettype wire

### sv/tbd_octal_field.sv
// ----------------------------------------------------------------------------
// tbd_octal_field: octal text field accumulator
// Skips leading blanks, shifts in digits 0..7, and stops at the first other
// byte for the rest of the block. The accumulator wraps at its width.
// ----------------------------------------------------------------------------
`default_nettype none

module tbd_octal_field #(
    parameter int W = tbd_pkg::SMALL_W
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,     // a header byte is processed
    input  wire logic         i_clear,  // first byte of the block
    input  wire logic         i_sel,    // byte lies within this field
    input  wire logic [7:0]   i_byte,
    output logic      [W-1:0] o_value
);

    tbd_pkg::t_scan r_scan, n_scan;
    logic [W-1:0]   r_acc, n_acc;
    logic           is_digit;
    logic           is_blank;

    // Character classes
    always_comb begin
        is_digit = i_byte inside {[8'h30:8'h37]};
        is_blank = i_byte inside {8'h20, [8'h09:8'h0D]};
    end

    // Scan state and accumulator next values
    always_comb begin
        n_scan = r_scan;
        n_acc  = r_acc;
        if (i_en) begin
            if (i_clear) begin
                n_scan = tbd_pkg::SCAN_IDLE;
                n_acc  = '0;
            end else if (i_sel && r_scan != tbd_pkg::SCAN_STOPPED) begin
                if (is_digit) begin
                    n_acc  = {r_acc[W-4:0], i_byte[2:0]};
                    n_scan = tbd_pkg::SCAN_DIGITS;
                end else if (r_scan == tbd_pkg::SCAN_IDLE && is_blank) begin
                    n_scan = r_scan;
                end else begin
                    n_scan = tbd_pkg::SCAN_STOPPED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= tbd_pkg::SCAN_IDLE;
            r_acc  <= '0;
        end else begin
            r_scan <= n_scan;
            r_acc  <= n_acc;
        end
    end

    assign o_value = r_acc;

endmodule

`default_nettype wire

### sv/tar_block_stream_deframer.sv
// ----------------------------------------------------------------------------
// tar_block_stream_deframer: byte-serial tar archive deframer
// Classifies every archive byte, parses the octal header fields and reports
// entry metadata on the last byte of each named header block.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+------------------------------------------
//  input   | in  | i_valid / o_stall  | i_byte_in
//  output  | out | o_valid / i_stall  | o_byte_kind, o_byte_out, o_header_valid,
//          |     |                    | o_end_of_archive, o_entry_* fields
//
//  One byte per cycle sustained while the output is not stalled; each byte
//  passes an input register and then a result register. The octal
//  shift-add and the 36-bit data countdown are both updated per byte.
//  Synchronous active-low reset; all stream state returns to the start of a
//  header block. Output stall holds the result register and, once the input
//  register is also full, raises o_stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tar_block_stream_deframer #(
    parameter int BLOCK_BYTES = tbd_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input channel
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [7:0]                   i_byte_in,
    // output channel
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [2:0]                   o_byte_kind,
    output logic      [7:0]                   o_byte_out,
    output logic                              o_header_valid,
    output logic                              o_end_of_archive,
    output logic      [tbd_pkg::LARGE_W-1:0]  o_entry_size,
    output logic      [tbd_pkg::SMALL_W-1:0]  o_entry_mode,
    output logic      [tbd_pkg::SMALL_W-1:0]  o_entry_uid,
    output logic      [tbd_pkg::SMALL_W-1:0]  o_entry_gid,
    output logic      [tbd_pkg::LARGE_W-1:0]  o_entry_mtime
);

    localparam int OFS_W = $clog2(BLOCK_BYTES);
    localparam int SW    = tbd_pkg::SMALL_W;
    localparam int LW    = tbd_pkg::LARGE_W;

    // Input register
    logic            r_in_valid;
    logic [7:0]      r_in_byte;

    // Stream state
    tbd_pkg::t_phase r_phase, n_phase;
    logic [OFS_W-1:0] r_offset, n_offset;
    logic            r_all_zero, n_all_zero;
    logic            r_prev_zero, n_prev_zero;
    logic            r_name_empty, n_name_empty;
    logic [LW-1:0]   r_remain, n_remain;

    // Result register
    logic            r_out_valid;
    logic [2:0]      r_kind, n_kind;
    logic [7:0]      r_byte;
    logic            r_hdr, n_hdr;
    logic            r_eoa, n_eoa;
    logic [LW-1:0]   r_size, n_size;
    logic [SW-1:0]   r_mode, n_mode;
    logic [SW-1:0]   r_uid, n_uid;
    logic [SW-1:0]   r_gid, n_gid;
    logic [LW-1:0]   r_mtime, n_mtime;

    // Field accumulators
    logic [SW-1:0]   mode_acc, uid_acc, gid_acc;
    logic [LW-1:0]   size_acc, mtime_acc;

    logic            advance;
    logic            proc;
    logic            hdr_en;
    logic            first;
    logic            last;
    logic            sel_mode, sel_uid, sel_gid, sel_size, sel_mtime;
    logic [LW-1:0]   remain_dec;

    // Pipeline control
    assign advance = !r_out_valid || !i_stall;
    assign proc    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign hdr_en  = proc && (r_phase == tbd_pkg::PH_HEADER);
    assign first   = (r_offset == '0);
    assign last    = (r_offset == OFS_W'(BLOCK_BYTES - 1));

    // Header field windows
    always_comb begin
        sel_mode  = (r_offset >= OFS_W'(tbd_pkg::OFS_MODE))
                 && (r_offset <  OFS_W'(tbd_pkg::OFS_UID));
        sel_uid   = (r_offset >= OFS_W'(tbd_pkg::OFS_UID))
                 && (r_offset <  OFS_W'(tbd_pkg::OFS_GID));
        sel_gid   = (r_offset >= OFS_W'(tbd_pkg::OFS_GID))
                 && (r_offset <  OFS_W'(tbd_pkg::OFS_SIZE));
        sel_size  = (r_offset >= OFS_W'(tbd_pkg::OFS_SIZE))
                 && (r_offset <  OFS_W'(tbd_pkg::OFS_MTIME));
        sel_mtime = (r_offset >= OFS_W'(tbd_pkg::OFS_MTIME))
                 && (r_offset <  OFS_W'(tbd_pkg::OFS_FIELDS_END));
    end

    tbd_octal_field #(.W(SW)) u_mode (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(hdr_en), .i_clear(first),
        .i_sel(sel_mode), .i_byte(r_in_byte), .o_value(mode_acc)
    );

    tbd_octal_field #(.W(SW)) u_uid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(hdr_en), .i_clear(first),
        .i_sel(sel_uid), .i_byte(r_in_byte), .o_value(uid_acc)
    );

    tbd_octal_field #(.W(SW)) u_gid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(hdr_en), .i_clear(first),
        .i_sel(sel_gid), .i_byte(r_in_byte), .o_value(gid_acc)
    );

    tbd_octal_field #(.W(LW)) u_size (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(hdr_en), .i_clear(first),
        .i_sel(sel_size), .i_byte(r_in_byte), .o_value(size_acc)
    );

    tbd_octal_field #(.W(LW)) u_mtime (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(hdr_en), .i_clear(first),
        .i_sel(sel_mtime), .i_byte(r_in_byte), .o_value(mtime_acc)
    );

    assign remain_dec = r_remain - LW'(1);

    // Phase sequencing and result formation
    always_comb begin
        n_phase      = r_phase;
        n_offset     = r_offset;
        n_all_zero   = r_all_zero;
        n_prev_zero  = r_prev_zero;
        n_name_empty = r_name_empty;
        n_remain     = r_remain;
        n_kind       = tbd_pkg::KIND_AFTER;
        n_hdr        = 1'b0;
        n_eoa        = 1'b0;
        n_size       = '0;
        n_mode       = '0;
        n_uid        = '0;
        n_gid        = '0;
        n_mtime      = '0;
        if (proc) begin
            n_offset = last ? '0 : r_offset + OFS_W'(1);
            case (r_phase)
                tbd_pkg::PH_HEADER: begin
                    n_all_zero   = (first || r_all_zero) && (r_in_byte == 8'h00);
                    n_name_empty = first ? (r_in_byte == 8'h00) : r_name_empty;
                    n_kind       = n_all_zero ? tbd_pkg::KIND_ZERO
                                              : tbd_pkg::KIND_HEADER;
                    if (last) begin
                        if (n_all_zero) begin
                            if (r_prev_zero) begin
                                n_eoa   = 1'b1;
                                n_phase = tbd_pkg::PH_DONE;
                            end else begin
                                n_prev_zero = 1'b1;
                            end
                        end else begin
                            n_prev_zero = 1'b0;
                            if (!n_name_empty) begin
                                n_hdr    = 1'b1;
                                n_size   = size_acc;
                                n_mode   = mode_acc;
                                n_uid    = uid_acc;
                                n_gid    = gid_acc;
                                n_mtime  = mtime_acc;
                                n_remain = size_acc;
                                if (size_acc != '0) begin
                                    n_phase = tbd_pkg::PH_DATA;
                                end
                            end
                        end
                    end
                end
                tbd_pkg::PH_DATA: begin
                    n_kind   = tbd_pkg::KIND_DATA;
                    n_remain = remain_dec;
                    if (remain_dec == '0) begin
                        n_phase = last ? tbd_pkg::PH_HEADER : tbd_pkg::PH_PAD;
                    end
                end
                tbd_pkg::PH_PAD: begin
                    n_kind = tbd_pkg::KIND_PAD;
                    if (last) begin
                        n_phase = tbd_pkg::PH_HEADER;
                    end
                end
                default: begin
                    // archive ended: offset frozen, byte tagged as trailing
                    n_kind   = tbd_pkg::KIND_AFTER;
                    n_offset = r_offset;
                end
            endcase
        end
    end

    // Stream state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tbd_pkg::PH_HEADER;
            r_offset     <= '0;
            r_all_zero   <= 1'b1;
            r_prev_zero  <= 1'b0;
            r_name_empty <= 1'b0;
            r_remain     <= '0;
        end else begin
            r_phase      <= n_phase;
            r_offset     <= n_offset;
            r_all_zero   <= n_all_zero;
            r_prev_zero  <= n_prev_zero;
            r_name_empty <= n_name_empty;
            r_remain     <= n_remain;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_byte_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_kind  <= n_kind;
            r_byte  <= r_in_byte;
            r_hdr   <= n_hdr;
            r_eoa   <= n_eoa;
            r_size  <= n_size;
            r_mode  <= n_mode;
            r_uid   <= n_uid;
            r_gid   <= n_gid;
            r_mtime <= n_mtime;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_byte_kind      = r_kind;
    assign o_byte_out       = r_byte;
    assign o_header_valid   = r_hdr;
    assign o_end_of_archive = r_eoa;
    assign o_entry_size     = r_size;
    assign o_entry_mode     = r_mode;
    assign o_entry_uid      = r_uid;
    assign o_entry_gid      = r_gid;
    assign o_entry_mtime    = r_mtime;

    // Checks
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tbd_pkg::PH_DONE |=> r_phase == tbd_pkg::PH_DONE)
        else $error("deframer left the archive-end phase");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled with room in the pipeline");

    a_hdr_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_hdr |-> r_kind == tbd_pkg::KIND_HEADER && !r_eoa)
        else $error("header report on a non-header byte");

    a_eoa_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_eoa |-> r_kind == tbd_pkg::KIND_ZERO
                                 && r_phase == tbd_pkg::PH_DONE)
        else $error("end of archive flagged outside a zero block");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tbd_pkg::PH_DATA |-> r_remain != '0)
        else $error("data phase with nothing left to pass");

endmodule

`default_nettype wire
